@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the framed command handler RTL.
// Needs no other file; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Property must never hold at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/fch_pkg.sv @@
// Shared types and constants of the framed command handler.
// No dependencies; used by every module in rtl/core.
package fch_pkg;

  localparam logic [7:0] StartByteReset  = 8'h40;
  localparam logic [7:0] ReplyLenStatus  = 8'd7;
  localparam logic [7:0] ReplyLenTemp    = 8'd4;
  localparam logic [7:0] DevAllSet       = 8'hFF;
  localparam logic [7:0] DevAllClear     = 8'h00;
  localparam logic [3:0] AllDevices      = 4'hF;
  localparam int unsigned QueueDepthDefault = 2;
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] LastIdxStatus = 4'd8;
  localparam logic [IdxW-1:0] LastIdxTemp   = 4'd5;

  localparam logic [1:0] CmdClear  = 2'd0;
  localparam logic [1:0] CmdSet    = 2'd1;
  localparam logic [1:0] CmdStatus = 2'd2;
  localparam logic [1:0] CmdTemp   = 2'd3;

  typedef struct packed {
    logic       is_temp;
    logic [1:0] cmd;
    logic [3:0] dev;
    logic [7:0] temp;
    logic [7:0] start;
  } desc_t;

endpackage

@@ rtl/core/fch_front.sv @@
// Frame parser: hunts start bytes, accumulates checksum, updates devices.
// Depends on fch_pkg; pushes reply descriptors toward fch_queue.
module fch_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i,
  input  logic          accept_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    temperature_i,
  output logic          push_o,
  output fch_pkg::desc_t push_data_o
);

  logic [7:0]  start_q;
  logic [8:0]  pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  logic [3:0]  set_q, set_d;
  logic [3:0]  clr_q, clr_d;
  logic [3:0]  dev_q, dev_d;
  logic [15:0] sum_add;
  logic [3:0]  dev_bit;
  logic        chk_ok;

  assign sum_add = sum_q + {8'd0, rx_byte_i};
  assign dev_bit = 4'b0001 << 2'(rx_byte_i - 8'd1);
  assign chk_ok  = ({chk_hi_q, rx_byte_i} == sum_q);

  always_comb begin
    pos_d       = pos_q;
    len_d       = len_q;
    cmd_d       = cmd_q;
    sum_d       = sum_q;
    chk_hi_d    = chk_hi_q;
    set_d       = set_q;
    clr_d       = clr_q;
    dev_d       = dev_q;
    push_o      = 1'b0;
    push_data_o = '0;
    if (accept_i) begin
      if (rx_byte_i == start_q) begin
        pos_d = 9'd1; len_d = '0; cmd_d = '0; sum_d = '0;
        chk_hi_d = '0; set_d = '0; clr_d = '0;
      end else if (pos_q == 9'd0) begin
        pos_d = pos_q;
      end else if (pos_q == 9'd1) begin
        len_d = rx_byte_i;
        sum_d = {8'd0, rx_byte_i};
        pos_d = 9'd2;
        if (rx_byte_i < 8'd3) begin
          pos_d = '0; len_d = '0; sum_d = '0;
        end
      end else if (pos_q == 9'd2) begin
        cmd_d = rx_byte_i;
        sum_d = sum_add;
        pos_d = 9'd3;
      end else if (pos_q < {1'b0, len_q}) begin
        sum_d = sum_add;
        if (rx_byte_i inside {[8'd1:8'd4]}) begin
          set_d = set_q | dev_bit;
          clr_d = clr_q | dev_bit;
        end else if (rx_byte_i == fch_pkg::DevAllSet) begin
          set_d = fch_pkg::AllDevices;
        end else if (rx_byte_i == fch_pkg::DevAllClear) begin
          clr_d = fch_pkg::AllDevices;
        end
        pos_d = pos_q + 9'd1;
      end else if (pos_q == {1'b0, len_q}) begin
        chk_hi_d = rx_byte_i;
        pos_d    = pos_q + 9'd1;
      end else begin
        if (chk_ok && cmd_q[7:2] == 6'd0) begin
          if (cmd_q[1:0] == fch_pkg::CmdSet) begin
            dev_d = dev_q | set_q;
          end else if (cmd_q[1:0] == fch_pkg::CmdClear) begin
            dev_d = dev_q & ~clr_q;
          end
          push_o              = 1'b1;
          push_data_o.is_temp = (cmd_q[1:0] == fch_pkg::CmdTemp);
          push_data_o.cmd     = cmd_q[1:0];
          push_data_o.dev     = dev_d;
          push_data_o.temp    = temperature_i;
          push_data_o.start   = start_q;
        end
        pos_d = '0; len_d = '0; cmd_d = '0; sum_d = '0;
        chk_hi_d = '0; set_d = '0; clr_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= fch_pkg::StartByteReset;
      pos_q    <= '0;
      len_q    <= '0;
      cmd_q    <= '0;
      sum_q    <= '0;
      chk_hi_q <= '0;
      set_q    <= '0;
      clr_q    <= '0;
      dev_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
      pos_q    <= pos_d;
      len_q    <= len_d;
      cmd_q    <= cmd_d;
      sum_q    <= sum_d;
      chk_hi_q <= chk_hi_d;
      set_q    <= set_d;
      clr_q    <= clr_d;
      dev_q    <= dev_d;
    end
  end

endmodule

@@ rtl/core/fch_queue.sv @@
// Small descriptor FIFO between the parser and the reply serializer.
// Depends on fch_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fch_queue #(
  parameter int unsigned Depth = fch_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fch_pkg::desc_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output fch_pkg::desc_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  fch_pkg::desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push_i && full_o)
  `ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, pop_i && !valid_o)

endmodule

@@ rtl/core/fch_back.sv @@
// Reply serializer: walks one descriptor into 6 or 9 reply bytes.
// Depends on fch_pkg and assert_macros.svh; reads the head of fch_queue.
`include "assert_macros.svh"
module fch_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  fch_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [7:0]     m_byte_o,
  output logic           m_last_o,
  output logic [3:0]     m_dev_o
);

  logic [fch_pkg::IdxW-1:0] idx_q;
  logic [fch_pkg::IdxW-1:0] last_idx;
  logic       valid_q;
  logic [7:0] byte_q, byte_sel;
  logic       last_q;
  logic [3:0] dev_q;
  logic       load;
  logic       is_last;
  logic [7:0] status_sum, temp_sum;

  assign last_idx = head_i.is_temp ? fch_pkg::LastIdxTemp : fch_pkg::LastIdxStatus;
  assign is_last  = (idx_q == last_idx);
  assign load     = head_valid_i && (!valid_q || m_ready_i);
  assign pop_o    = load && is_last;

  assign status_sum = fch_pkg::ReplyLenStatus + {6'd0, head_i.cmd}
                    + {7'd0, head_i.dev[0]} + {7'd0, head_i.dev[1]}
                    + {7'd0, head_i.dev[2]} + {7'd0, head_i.dev[3]};
  assign temp_sum   = fch_pkg::ReplyLenTemp + {6'd0, fch_pkg::CmdTemp} + head_i.temp;

  always_comb begin
    byte_sel = '0;
    if (head_i.is_temp) begin
      case (idx_q)
        4'd0:    byte_sel = head_i.start;
        4'd1:    byte_sel = fch_pkg::ReplyLenTemp;
        4'd2:    byte_sel = {6'd0, head_i.cmd};
        4'd3:    byte_sel = head_i.temp;
        4'd5:    byte_sel = temp_sum;
        default: byte_sel = '0;
      endcase
    end else begin
      case (idx_q)
        4'd0:    byte_sel = head_i.start;
        4'd1:    byte_sel = fch_pkg::ReplyLenStatus;
        4'd2:    byte_sel = {6'd0, head_i.cmd};
        4'd3:    byte_sel = {7'd0, head_i.dev[0]};
        4'd4:    byte_sel = {7'd0, head_i.dev[1]};
        4'd5:    byte_sel = {7'd0, head_i.dev[2]};
        4'd6:    byte_sel = {7'd0, head_i.dev[3]};
        4'd8:    byte_sel = status_sum;
        default: byte_sel = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? '0 : idx_q + 1'b1;
      end else if (m_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_sel;
      last_q <= is_last;
      dev_q  <= head_i.dev;
    end
  end

  assign m_valid_o = valid_q;
  assign m_byte_o  = byte_q;
  assign m_last_o  = last_q;
  assign m_dev_o   = dev_q;

  `ASSERT_ALWAYS(a_idx_restart, clk_i, rst_ni, pop_o |=> idx_q == '0)
  `ASSERT_ALWAYS(a_idx_range, clk_i, rst_ni, idx_q <= fch_pkg::LastIdxStatus)

endmodule

@@ rtl/core/framed_command_handler.sv @@
// Top level of the framed command handler: parser, descriptor queue, serializer.
// Depends on fch_pkg, fch_front, fch_queue and fch_back.
//
// Input stream carries received bytes with the current temperature reading.
// Frames are: start byte, length, command, data bytes, checksum high, low.
// The parser takes one byte per cycle while tready is high. A frame with a
// good checksum and a command of 0..3 queues one reply descriptor on its
// final byte. The serializer turns a descriptor into 9 bytes (commands 0..2)
// or 6 bytes (command 3), one byte per cycle while the receiver is ready,
// tlast on the final byte. The first reply byte passes through the
// descriptor queue and the output register before it is valid.
// Input tready drops only while the descriptor queue (QueueDepth entries)
// is full, which happens when the receiver stalls or frames close faster
// than replies drain. A stalled output holds its byte; the parser keeps
// running until the queue fills.
// The start byte register is written by cfg_we_i/cfg_wdata_i, reset 0x40.
// Reset clears the parser, the queue, the output valid flag and all devices.
module framed_command_handler #(
  parameter int unsigned QueueDepth = fch_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] rx_byte, [15:8] temperature
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // [7:0] tx_byte, [11:8] device_state, [15:12] zero
  output logic        m_axis_tlast_o   // last_byte
);

  logic           accept;
  logic           push, pop, full, head_valid;
  fch_pkg::desc_t push_data, head;
  logic [7:0]     tx_byte;
  logic [3:0]     dev_state;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  fch_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .rx_byte_i    (s_axis_tdata_i[7:0]),
    .temperature_i(s_axis_tdata_i[15:8]),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  fch_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .full_o     (full),
    .valid_o    (head_valid),
    .head_o     (head)
  );

  fch_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_byte_o    (tx_byte),
    .m_last_o    (m_axis_tlast_o),
    .m_dev_o     (dev_state)
  );

  assign m_axis_tdata_o = {4'd0, dev_state, tx_byte};

endmodule
